>>> design/dpa_pkg.sv
// Shared types and constants for the demodulator path allocator.
`timescale 1ns / 1ps
package dpa_pkg;

	localparam int DPA_NUM_PATHS = 8;
	localparam int DPA_TAG_BITS  = 16;

	localparam int KIND_W   = 2;
	localparam int TAG_W    = 16;
	localparam int POWER_W  = 10;
	localparam int SF_W     = 4;
	localparam int STATUS_W = 4;
	localparam int PIDX_W   = 3;
	localparam int MASK_W   = 8;
	localparam int OCC_W    = 4;
	localparam int PIU_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int NUM_SENS   = 6;

	localparam logic [SF_W-1:0] SF_LOW  = 4'd7;
	localparam logic [SF_W-1:0] SF_HIGH = 4'd12;

	localparam logic [PIU_W-1:0] PIU_RESET = 4'd8;
	localparam logic signed [POWER_W-1:0] SENS_SF7_RESET  = -10'sd253;
	localparam logic signed [POWER_W-1:0] SENS_SF8_RESET  = -10'sd258;
	localparam logic signed [POWER_W-1:0] SENS_SF9_RESET  = -10'sd263;
	localparam logic signed [POWER_W-1:0] SENS_SF10_RESET = -10'sd268;
	localparam logic signed [POWER_W-1:0] SENS_SF11_RESET = -10'sd273;
	localparam logic signed [POWER_W-1:0] SENS_SF12_RESET = -10'sd279;

	typedef enum logic [KIND_W-1:0] {
		KIND_RX_START = 2'd0,
		KIND_RX_END   = 2'd1,
		KIND_TX_START = 2'd2,
		KIND_TX_END   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPT      = 4'd0,
		ST_DROP_TX     = 4'd1,
		ST_UNDER_SENS  = 4'd2,
		ST_NO_PATH     = 4'd3,
		ST_OK          = 4'd4,
		ST_INTERFERED  = 4'd5,
		ST_TX_START    = 4'd6,
		ST_TX_END      = 4'd7,
		ST_UNKNOWN_TAG = 4'd8,
		ST_BAD_SF      = 4'd9
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATHS_IN_USE = 3'd0,
		CFG_SENS_SF7     = 3'd1,
		CFG_SENS_SF8     = 3'd2,
		CFG_SENS_SF9     = 3'd3,
		CFG_SENS_SF10    = 3'd4,
		CFG_SENS_SF11    = 3'd5,
		CFG_SENS_SF12    = 3'd6
	} cfg_idx_t;

	// Command broadcast from the controller to every path cell.
	typedef struct packed {
		logic alloc;  // lock the first free enabled cell on the tag
		logic retire; // free the first busy cell whose tag matches
		logic flush;  // free every cell
	} cell_cmd_t;

endpackage

>>> design/dpa_if.sv
// Valid/ready channels carrying request and result words.
`timescale 1ns / 1ps
interface dpa_req_if;
	import dpa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [TAG_W-1:0]          rx_tag;
	logic signed [POWER_W-1:0] rx_power;
	logic [SF_W-1:0]           spreading_factor;
	logic                      interfered;

	modport source (output valid, kind, rx_tag, rx_power, spreading_factor, interfered,
		input ready);
	modport sink (input valid, kind, rx_tag, rx_power, spreading_factor, interfered,
		output ready);
endinterface

interface dpa_rsp_if;
	import dpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PIDX_W-1:0]   path_index;
	logic [MASK_W-1:0]   interrupted_mask;
	logic [OCC_W-1:0]    occupied_count;

	modport source (output valid, status, path_index, interrupted_mask, occupied_count,
		input ready);
	modport sink (input valid, status, path_index, interrupted_mask, occupied_count,
		output ready);
endinterface

>>> design/dpa_cell.sv
// One demodulator path: busy flag, locked tag and priority chain links.
`timescale 1ns / 1ps
module dpa_cell
	import dpa_pkg::*;
#(
	parameter int TAG_BITS = DPA_TAG_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  logic                enabled,
	input  logic [TAG_BITS-1:0] tag,
	input  logic                free_in,  // a lower cell already offers itself
	input  logic                match_in, // a lower cell already matches
	output logic                free_out,
	output logic                match_out,
	output logic                alloc_win,
	output logic                match_win,
	output logic                busy
);

	logic                busy_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                is_free;
	logic                is_match;

	assign is_free   = enabled && !busy_q;
	assign is_match  = busy_q && (tag_q == tag);
	assign alloc_win = is_free && !free_in;
	assign match_win = is_match && !match_in;
	assign free_out  = free_in || is_free;
	assign match_out = match_in || is_match;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.flush) begin
			busy_q <= 1'b0;
		end else if (cmd.alloc && alloc_win) begin
			busy_q <= 1'b1;
		end else if (cmd.retire && match_win) begin
			busy_q <= 1'b0;
		end
	end

	// tag is only read while busy, so it needs no reset
	always_ff @(posedge clk) begin
		if (cmd.alloc && alloc_win) begin
			tag_q <= tag;
		end
	end

endmodule

>>> design/demodulator_path_allocator.sv
// Top level of the demodulator path allocator: controller and row of path cells.
`timescale 1ns / 1ps
// Demodulator path allocator. Each request word (reception start/end, transmit
// start/end) yields exactly one result word. The block takes one request per
// clock: the paths form a row of cells, and the free-path search and tag match
// ripple through that row as priority chains within the cycle, so path 0 wins
// over path 1 and so on. The result sits in an output register from the cycle after
// acceptance; a new request is taken in the same cycle that the pending result
// is taken, so throughput is one word per clock while the sink keeps up.
// Configuration is a plain write port: index 0 sets paths_in_use (and frees
// every path), indexes 1..6 set the SF7..SF12 sensitivity thresholds in signed
// half-dBm units, higher indexes are ignored. Write configuration only while
// idle. No clearing pass is needed after reset.
module demodulator_path_allocator
	import dpa_pkg::*;
#(
	parameter int NUM_PATHS = DPA_NUM_PATHS,
	parameter int TAG_BITS  = DPA_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dpa_req_if.sink               req,
	dpa_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int CNT_W = $clog2(NUM_PATHS + 1);

	// configuration
	logic [PIU_W-1:0]          paths_q;
	logic signed [POWER_W-1:0] sens_q [NUM_SENS];

	// control state
	logic                      tx_q;
	logic [CNT_W-1:0]          count_q;

	// cell row
	cell_cmd_t                 cmd;
	logic [NUM_PATHS-1:0]      enabled;
	logic [NUM_PATHS:0]        free_chain;
	logic [NUM_PATHS:0]        match_chain;
	logic [NUM_PATHS-1:0]      alloc_win;
	logic [NUM_PATHS-1:0]      match_win;
	logic [NUM_PATHS-1:0]      busy_vec;
	logic [TAG_BITS-1:0]       tag;

	// decision
	logic                      accept;
	logic                      cfg_flush;
	logic                      sf_ok;
	logic signed [POWER_W-1:0] sens_sel;
	logic [IDX_W-1:0]          alloc_idx;
	logic [IDX_W-1:0]          match_idx;
	status_t                   status_d;
	logic [IDX_W-1:0]          idx_d;
	logic [NUM_PATHS-1:0]      mask_d;
	logic [CNT_W-1:0]          count_d;
	logic                      tx_d;

	// output register
	logic                      rsp_valid_q;
	status_t                   status_q;
	logic [PIDX_W-1:0]         idx_q;
	logic [MASK_W-1:0]         mask_q;
	logic [OCC_W-1:0]          occ_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign tag       = TAG_BITS'(req.rx_tag);
	assign cfg_flush = cfg_we && (cfg_index == CFG_PATHS_IN_USE);

	assign free_chain[0]  = 1'b0;
	assign match_chain[0] = 1'b0;

	for (genvar i = 0; i < NUM_PATHS; i++) begin : g_path
		assign enabled[i] = (PIU_W'(i) < paths_q);

		dpa_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.enabled  (enabled[i]),
			.tag      (tag),
			.free_in  (free_chain[i]),
			.match_in (match_chain[i]),
			.free_out (free_chain[i+1]),
			.match_out(match_chain[i+1]),
			.alloc_win(alloc_win[i]),
			.match_win(match_win[i]),
			.busy     (busy_vec[i])
		);
	end

	// winners are one-hot, so OR of their indexes encodes them
	always_comb begin
		alloc_idx = '0;
		match_idx = '0;
		for (int i = 0; i < NUM_PATHS; i++) begin
			if (alloc_win[i]) alloc_idx = alloc_idx | IDX_W'(i);
			if (match_win[i]) match_idx = match_idx | IDX_W'(i);
		end
	end

	assign sf_ok = (req.spreading_factor >= SF_LOW) && (req.spreading_factor <= SF_HIGH);

	always_comb begin
		case (req.spreading_factor)
			4'd7:    sens_sel = sens_q[0];
			4'd8:    sens_sel = sens_q[1];
			4'd9:    sens_sel = sens_q[2];
			4'd10:   sens_sel = sens_q[3];
			4'd11:   sens_sel = sens_q[4];
			default: sens_sel = sens_q[5];
		endcase
	end

	always_comb begin
		cmd      = '0;
		status_d = ST_TX_END;
		idx_d    = '0;
		mask_d   = '0;
		count_d  = count_q;
		tx_d     = tx_q;
		unique case (kind_t'(req.kind))
			KIND_RX_START: begin
				if (tx_q) begin
					status_d = ST_DROP_TX;
				end else if (!sf_ok) begin
					status_d = ST_BAD_SF;
				end else if (!free_chain[NUM_PATHS]) begin
					status_d = ST_NO_PATH;
				end else if (req.rx_power < sens_sel) begin
					status_d = ST_UNDER_SENS;
				end else begin
					status_d  = ST_ACCEPT;
					cmd.alloc = accept;
					idx_d     = alloc_idx;
					count_d   = count_q + CNT_W'(1);
				end
			end
			KIND_RX_END: begin
				if (!match_chain[NUM_PATHS]) begin
					status_d = ST_UNKNOWN_TAG;
				end else begin
					status_d   = req.interfered ? ST_INTERFERED : ST_OK;
					cmd.retire = accept;
					idx_d      = match_idx;
					if (count_q != '0) count_d = count_q - CNT_W'(1);
				end
			end
			KIND_TX_START: begin
				status_d  = ST_TX_START;
				mask_d    = busy_vec;
				cmd.flush = accept;
				count_d   = '0;
				tx_d      = 1'b1;
			end
			KIND_TX_END: begin
				status_d = ST_TX_END;
				tx_d     = 1'b0;
			end
			default: begin
				status_d = ST_TX_END;
			end
		endcase
		if (cfg_flush) cmd.flush = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paths_q <= PIU_RESET;
			sens_q[0] <= SENS_SF7_RESET;
			sens_q[1] <= SENS_SF8_RESET;
			sens_q[2] <= SENS_SF9_RESET;
			sens_q[3] <= SENS_SF10_RESET;
			sens_q[4] <= SENS_SF11_RESET;
			sens_q[5] <= SENS_SF12_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATHS_IN_USE: paths_q   <= cfg_data[PIU_W-1:0];
				CFG_SENS_SF7:     sens_q[0] <= cfg_data;
				CFG_SENS_SF8:     sens_q[1] <= cfg_data;
				CFG_SENS_SF9:     sens_q[2] <= cfg_data;
				CFG_SENS_SF10:    sens_q[3] <= cfg_data;
				CFG_SENS_SF11:    sens_q[4] <= cfg_data;
				CFG_SENS_SF12:    sens_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q    <= 1'b0;
			count_q <= '0;
		end else if (cfg_flush) begin
			count_q <= '0;
		end else if (accept) begin
			tx_q    <= tx_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			idx_q    <= PIDX_W'(idx_d);
			mask_q   <= MASK_W'(mask_d);
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.path_index       = idx_q;
	assign rsp.interrupted_mask = mask_q;
	assign rsp.occupied_count   = occ_q;

endmodule
